FILE: design/ftws_pkg.sv
// Shared types and constants for the frame time window statistics unit.
// Used by ftws_ctrl, ftws_dp and frame_time_window_stats_unit.
package ftws_pkg;

  localparam int unsigned TS_W         = 64;
  localparam int unsigned MS_W         = 32;
  localparam int unsigned FILLED_W     = 7;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned FPS_SCALE    = 1000;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE = 1'b0;
  localparam logic [31:0] TICK_SCALE_RST = 32'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_END    = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_CLEAR  = 2'd3
  } ftws_cmd_e;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch the incoming timestamp
    logic begin_seg;   // open a segment if none is open
    logic clear_hist;  // empty the sample window
    logic delta;       // elapsed ticks of the open segment
    logic accum;       // close segment, saturating add into accumulator
    logic mul_hi;      // upper accumulator half times scale
    logic mul_lo;      // lower accumulator half times scale
    logic conv;        // finish conversion, store sample, start scan
    logic div_start;   // start the fps division
    logic load_out;    // load the result register
  } ftws_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_busy;
    logic div_busy;
    logic out_free;
  } ftws_sts_t;

endpackage

FILE: design/ftws_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Used by ftws_dp for the average frames per second.
module ftws_div #(
  parameter int unsigned NUM_W = 52,
  parameter int unsigned DEN_W = 39
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract where the divisor fits
      if (fits) begin
        rem_q <= DEN_W'(shifted - {1'b0, den_q});
      end else begin
        rem_q <= shifted[DEN_W-1:0];
      end
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

FILE: design/ftws_ctrl.sv
// Sequencing state machine for the frame time window statistics unit.
// Depends on ftws_pkg for the command codes and the control structs.
module ftws_ctrl
  import ftws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  ftws_cmd_e  in_cmd_i,
  output logic       in_ready_o,
  input  ftws_sts_t  sts_i,
  output ftws_ctl_t  ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_ACCUM,
    S_MUL_HI,
    S_MUL_LO,
    S_CONV,
    S_SCAN,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   commit_q, commit_d;

  always_comb begin
    ctl_o      = '0;
    state_d    = state_q;
    commit_d   = commit_q;
    in_ready_o = (state_q == S_IDLE);
    ctl_o.take = in_valid_i && in_ready_o;
    unique case (state_q)
      S_IDLE: begin
        if (ctl_o.take) begin
          unique case (in_cmd_i)
            CMD_BEGIN:  ctl_o.begin_seg  = 1'b1;
            CMD_CLEAR:  ctl_o.clear_hist = 1'b1;
            CMD_END: begin
              commit_d = 1'b0;
              state_d  = S_DELTA;
            end
            CMD_COMMIT: begin
              commit_d = 1'b1;
              state_d  = S_DELTA;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DELTA: begin
        ctl_o.delta = 1'b1;
        state_d     = S_ACCUM;
      end
      S_ACCUM: begin
        ctl_o.accum = 1'b1;
        state_d     = commit_q ? S_MUL_HI : S_IDLE;
      end
      S_MUL_HI: begin
        ctl_o.mul_hi = 1'b1;
        state_d      = S_MUL_LO;
      end
      S_MUL_LO: begin
        ctl_o.mul_lo = 1'b1;
        state_d      = S_CONV;
      end
      S_CONV: begin
        ctl_o.conv = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (!sts_i.scan_busy) begin
          ctl_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      commit_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      commit_q <= commit_d;
    end
  end

endmodule

FILE: design/ftws_dp.sv
// Datapath: segment timing, tick conversion, sample ring, window scan,
// fps division and the result register. Depends on ftws_pkg and ftws_div.
module ftws_dp
  import ftws_pkg::*;
#(
  parameter int unsigned HISTORY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ftws_ctl_t            ctl_i,
  output ftws_sts_t            sts_o,
  input  logic [TS_W-1:0]      ts_i,
  input  logic [31:0]          tick_scale_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [MS_W-1:0]      last_ms_o,
  output logic [MS_W-1:0]      min_ms_o,
  output logic [MS_W-1:0]      max_ms_o,
  output logic [MS_W-1:0]      fps_avg_o,
  output logic [FILLED_W-1:0]  filled_o,
  output logic [$clog2(HISTORY+1)-1:0] fill_o
);

  localparam int unsigned CW    = $clog2(HISTORY + 1);
  localparam int unsigned AW    = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int unsigned SUM_W = MS_W + CW;
  localparam int unsigned FK_W  = $clog2(FPS_SCALE * HISTORY + 1);
  localparam int unsigned NUM_W = FK_W + 32;

  // segment and accumulator
  logic [TS_W-1:0] ts_q, seg_start_q, delta_q, acc_q;
  logic            seg_open_q;
  logic [TS_W:0]   acc_sum;

  // conversion
  logic [31:0]     mul_a;
  logic [63:0]     prod, hp_q, lp_q;
  logic [48:0]     conv_total;
  logic            conv_sat;
  logic [MS_W-1:0] ms, ms_q;

  // ring and scan
  logic [MS_W-1:0]  ring_mem [HISTORY];
  logic [AW-1:0]    wp_q;
  logic [CW-1:0]    fill_q, idx_q;
  logic             scan_act_q, rd_vld_q;
  logic [MS_W-1:0]  rd_data_q, min_q, max_q;
  logic [SUM_W-1:0] sum_q;

  // division
  logic [FK_W-1:0]  fps_num;
  logic [NUM_W-1:0] quot;
  logic             div_busy;
  logic [MS_W-1:0]  fps;

  // result register
  logic            out_vld_q;
  logic [MS_W-1:0] out_last_q, out_min_q, out_max_q, out_fps_q;
  logic [CW-1:0]   out_fill_q;

  assign acc_sum = {1'b0, acc_q} + {1'b0, delta_q};

  assign mul_a = ctl_i.mul_hi ? acc_q[63:32] : acc_q[31:0];
  assign prod  = 64'(mul_a) * 64'(tick_scale_i);

  assign conv_total = {17'd0, hp_q[15:0], 16'd0} + {1'b0, lp_q[63:16]};
  assign conv_sat   = (hp_q[63:16] != '0) || (conv_total[48:32] != '0);
  assign ms         = conv_sat ? '1 : conv_total[31:0];

  assign fps_num = FK_W'(fill_q) * FK_W'(FPS_SCALE);

  ftws_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   ({fps_num, 32'd0}),
    .den_i   (sum_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_comb begin
    if (sum_q == '0) begin
      fps = '0;
    end else if (quot[NUM_W-1:32] != '0) begin
      fps = '1;
    end else begin
      fps = quot[31:0];
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_start_q <= '0;
      seg_open_q  <= 1'b0;
      acc_q       <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      scan_act_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      idx_q       <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (ctl_i.begin_seg && !seg_open_q) begin
        seg_start_q <= ts_i;
        seg_open_q  <= 1'b1;
      end
      if (ctl_i.clear_hist) begin
        wp_q   <= '0;
        fill_q <= '0;
      end
      if (ctl_i.accum && seg_open_q) begin
        acc_q      <= acc_sum[TS_W] ? '1 : acc_sum[TS_W-1:0];
        seg_open_q <= 1'b0;
      end
      if (ctl_i.conv) begin
        acc_q      <= '0;
        wp_q       <= (wp_q == AW'(HISTORY - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q < CW'(HISTORY)) fill_q <= fill_q + 1'b1;
        scan_act_q <= 1'b1;
        idx_q      <= '0;
      end else if (scan_act_q) begin
        // issue one ring read a cycle over the filled entries
        if (idx_q < fill_q) begin
          rd_vld_q <= 1'b1;
          idx_q    <= idx_q + 1'b1;
        end else begin
          rd_vld_q   <= 1'b0;
          scan_act_q <= 1'b0;
        end
      end else begin
        rd_vld_q <= 1'b0;
      end
      if (ctl_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) ts_q <= ts_i;
    if (ctl_i.delta) delta_q <= ts_q - seg_start_q;
    if (ctl_i.mul_hi) hp_q <= prod;
    if (ctl_i.mul_lo) lp_q <= prod;
    if (ctl_i.conv) begin
      ms_q  <= ms;
      min_q <= '1;
      max_q <= '0;
      sum_q <= '0;
    end else if (rd_vld_q) begin
      if (rd_data_q < min_q) min_q <= rd_data_q;
      if (rd_data_q > max_q) max_q <= rd_data_q;
      sum_q <= sum_q + SUM_W'(rd_data_q);
    end
    if (ctl_i.load_out) begin
      out_last_q <= ms_q;
      out_min_q  <= min_q;
      out_max_q  <= max_q;
      out_fps_q  <= fps;
      out_fill_q <= fill_q;
    end
  end

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.conv) ring_mem[wp_q] <= ms;
    rd_data_q <= ring_mem[idx_q[AW-1:0]];
  end

  assign sts_o.scan_busy = scan_act_q || rd_vld_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign last_ms_o   = out_last_q;
  assign min_ms_o    = out_min_q;
  assign max_ms_o    = out_max_q;
  assign fps_avg_o   = out_fps_q;
  assign filled_o    = FILLED_W'(out_fill_q);
  assign fill_o      = fill_q;

endmodule

FILE: design/frame_time_window_stats_unit.sv
// Top level of the frame time window statistics unit: stream ports,
// APB register, controller and datapath. Depends on ftws_pkg, ftws_ctrl, ftws_dp.
//
// Timestamped commands arrive on the slave stream (tuser carries the command,
// tdata the 64-bit counter value). Begin opens a timing segment, end adds
// its elapsed ticks (modulo-2^64 difference, so counter wrap is fine) to a
// saturating accumulator, clear empties the sample window, and commit closes
// any open segment, converts the accumulated ticks to Q16.16 milliseconds
// with tick_scale (ms per tick times 2^32, saturating), stores the sample in
// a HISTORY-entry ring and emits one item with the last, minimum and maximum
// sample, the average fps in Q16.16 (zero when all samples are zero) and the
// fill count. Only commit produces an item. Begin and clear act as they are
// taken, end also passes the delta and accumulate states, and commit runs
// longest: the window is read back one entry a cycle through the ring's
// single read port and the fps quotient, NUM_W = 32 + clog2(1000*HISTORY+1)
// bits (48 at HISTORY = 64), comes from a one-bit-per-cycle divider.
// A finished item sits in the output register while the next command is
// taken. The ring needs no clearing after reset: only written entries are
// ever scanned. Write tick_scale only while the unit is idle.
module frame_time_window_stats_unit
  import ftws_pkg::*;
#(
  parameter int unsigned HISTORY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TS_W-1:0]       s_axis_tdata,   // [63:0] timestamp
  input  logic [CMD_W-1:0]      s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] last_ms, [63:32] min_ms, [95:64] max_ms, [127:96] fps_avg,
  // [134:128] filled, [135] zero
  output logic [135:0]          m_axis_tdata,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW = $clog2(HISTORY + 1);

  logic [31:0]         tick_scale_q;
  logic [CFG_IDX_W-1:0] reg_idx;
  ftws_ctl_t           ctl;
  ftws_sts_t           sts;
  logic [MS_W-1:0]     last_ms, min_ms, max_ms, fps_avg;
  logic [FILLED_W-1:0] filled;
  logic [CW-1:0]       fill_cnt;

  // register file: one register at byte address 0
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_scale_q <= TICK_SCALE_RST;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_TICK_SCALE) begin
      tick_scale_q <= pwdata;
    end
  end

  assign prdata = (reg_idx == REG_TICK_SCALE) ? tick_scale_q : '0;

  ftws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (ftws_cmd_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ftws_dp #(
    .HISTORY (HISTORY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .ts_i         (s_axis_tdata),
    .tick_scale_i (tick_scale_q),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .last_ms_o    (last_ms),
    .min_ms_o     (min_ms),
    .max_ms_o     (max_ms),
    .fps_avg_o    (fps_avg),
    .filled_o     (filled),
    .fill_o       (fill_cnt)
  );

  assign m_axis_tdata = {1'b0, filled, fps_avg, max_ms, min_ms, last_ms};

  // the committed sample always lies inside the window's range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_ms <= last_ms && last_ms <= max_ms))
    else $error("last sample outside reported min/max");

  // an all-zero window reports zero fps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && max_ms == '0) |-> (fps_avg == '0))
    else $error("nonzero fps for an all-zero window");

  // fill count never runs past the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt <= CW'(HISTORY))
    else $error("fill count exceeds ring depth");

  // a new result is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(last_ms)))
    else $error("pending result overwritten");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for frame_time_window_stats_unit: a queue-fed command
// driver with a built-in predictor, a result monitor, and APB register access.
// Depends on ftws_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import ftws_pkg::*;

  localparam int unsigned WIN      = 64;
  localparam int unsigned IDLE_PCT = 37;
  localparam int unsigned HOLD_LEN = 1000;   // long receiver hold-off
  localparam int unsigned SETTLE   = 150;    // covers one commit plus slack
  localparam int unsigned LIMIT    = 5000;   // cycles with no item moving
  localparam int unsigned PHASE_N  = 270;    // random items per phase
  localparam logic [CFG_ADDR_W-1:0] TICK_SCALE_ADDR = CFG_ADDR_W'(4 * REG_TICK_SCALE);

  typedef struct packed {
    ftws_cmd_e        cmd;
    logic [TS_W-1:0]  ts;
  } cmd_item_t;

  typedef struct packed {
    logic [MS_W-1:0]     last_ms;
    logic [MS_W-1:0]     min_ms;
    logic [MS_W-1:0]     max_ms;
    logic [MS_W-1:0]     fps_avg;
    logic [FILLED_W-1:0] filled;
  } frame_stats_t;

  // ---------------------------------------------------------------- signals
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_valid       = 1'b0;
  logic                  s_axis_tready;
  logic [TS_W-1:0]       s_data        = '0;
  logic [CMD_W-1:0]      s_user        = '0;
  logic                  m_axis_tvalid;
  logic                  m_ready       = 1'b0;
  logic [135:0]          m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  frame_time_window_stats_unit #(.HISTORY(WIN)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------- shared bookkeeping
  cmd_item_t    cmd_pending[$];
  frame_stats_t stats_due[$];
  int unsigned  n_err    = 0;
  int unsigned  n_in     = 0;
  int unsigned  n_frames = 0;
  int unsigned  n_cfg    = 0;
  int unsigned  n_queued = 0;
  bit           calm     = 1'b0;   // no idling on either side
  bit           hold_req = 1'b0;   // ask the receiver for one long hold-off

  // ------------------------------------------------------- predictor state
  logic [31:0]     scale_q   = TICK_SCALE_RST;
  logic [TS_W-1:0] seg_t0    = '0;
  bit              seg_live  = 1'b0;
  logic [63:0]     tick_acc  = '0;
  logic [MS_W-1:0] win[WIN];
  int unsigned     win_wr    = 0;
  int unsigned     win_cnt   = 0;

  initial begin
    foreach (win[i]) win[i] = '0;
  end

  // Close an open segment, saturating the tick total.
  function automatic void close_seg(input logic [TS_W-1:0] now);
    logic [63:0] span;
    if (!seg_live) return;
    span = now - seg_t0;
    if (tick_acc > ~span) tick_acc = '1;
    else tick_acc = tick_acc + span;
    seg_live = 1'b0;
  endfunction

  // Advance the frame-stats state by one command; returns 1 with the
  // expected result when the command is a commit.
  function automatic bit frame_stats_step(input ftws_cmd_e c, input logic [TS_W-1:0] ts,
                                          output frame_stats_t r);
    logic [63:0]     hp, lp, tot, sum, num, quo;
    logic [MS_W-1:0] ms, mn, mx;
    r = '0;
    case (c)
      CMD_BEGIN: begin
        if (!seg_live) begin
          seg_t0   = ts;
          seg_live = 1'b1;
        end
        return 1'b0;
      end
      CMD_END: begin
        close_seg(ts);
        return 1'b0;
      end
      CMD_CLEAR: begin
        foreach (win[i]) win[i] = '0;
        win_wr  = 0;
        win_cnt = 0;
        return 1'b0;
      end
      default: ;
    endcase

    // commit: convert accumulated ticks to Q16.16 ms with saturation
    close_seg(ts);
    hp = {32'h0, tick_acc[63:32]} * {32'h0, scale_q};
    lp = {32'h0, tick_acc[31:0]} * {32'h0, scale_q};
    if (hp >= 64'h1_0000) begin
      ms = '1;
    end else begin
      tot = (hp << 16) + (lp >> 16);
      ms  = (tot > 64'hFFFF_FFFF) ? '1 : tot[31:0];
    end
    tick_acc = '0;

    win[win_wr] = ms;
    win_wr = (win_wr + 1 >= WIN) ? 0 : win_wr + 1;
    if (win_cnt < WIN) win_cnt++;

    mn  = '1;
    mx  = '0;
    sum = '0;
    for (int unsigned i = 0; i < win_cnt; i++) begin
      if (win[i] < mn) mn = win[i];
      if (win[i] > mx) mx = win[i];
      sum = sum + {32'h0, win[i]};
    end

    if (sum == 0) begin
      quo = '0;
    end else begin
      num = 64'(FPS_SCALE) * 64'(win_cnt);
      num = num << 32;
      quo = num / sum;
      if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
    end

    r.last_ms = ms;
    r.min_ms  = mn;
    r.max_ms  = mx;
    r.fps_avg = quo[31:0];
    r.filled  = FILLED_W'(win_cnt);
    return 1'b1;
  endfunction

  // ------------------------------------------------------- command driver
  // Present the next queued item, unless idling at random, whenever the current
  // one is taken or the bus is empty; predict each item at the edge where it is accepted.
  always @(posedge clk_i) begin : cmd_drive
    cmd_item_t    it;
    frame_stats_t r;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) begin
        n_in++;
        if (frame_stats_step(ftws_cmd_e'(s_user), s_data, r)) stats_due.push_back(r);
      end
      if (!s_valid || s_axis_tready) begin
        if (cmd_pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          it = cmd_pending.pop_front();
          s_valid <= 1'b1;
          s_data  <= it.ts;
          s_user  <= it.cmd;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------- result monitor
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  int unsigned hold_left  = 0;
  bit          hold_taken = 1'b0;

  always @(posedge clk_i) begin : stats_mon
    frame_stats_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_ready) begin
        n_frames++;
        if (stats_due.size() == 0) begin
          $error("unexpected result item: last_ms %0h", m_axis_tdata[31:0]);
          n_err++;
        end else begin
          want = stats_due.pop_front();
          check_field("last_ms", want.last_ms, m_axis_tdata[31:0]);
          check_field("min_ms",  want.min_ms,  m_axis_tdata[63:32]);
          check_field("max_ms",  want.max_ms,  m_axis_tdata[95:64]);
          check_field("fps_avg", want.fps_avg, m_axis_tdata[127:96]);
          check_field("filled",  32'(want.filled), 32'(m_axis_tdata[134:128]));
        end
      end
      // ready for the next cycle: long hold-off once, else random idling unless calm
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_LEN;
        m_ready    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ------------------------------------------------------- watchdog
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      quiet <= 0;
    end else if (quiet >= LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ------------------------------------------------------- register access
  task automatic reg_read_check(input logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TICK_SCALE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    // sample in the middle of the access phase
    @(negedge clk_i);
    check_field("tick_scale", want, prdata);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_tick_scale(input logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TICK_SCALE_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // register takes the value here
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scale_q = v;
    n_cfg++;
    reg_read_check(v);
  endtask

  // ------------------------------------------------------- stimulus helpers
  logic [TS_W-1:0] ts_now = '0;

  task automatic enq(input ftws_cmd_e c, input logic [TS_W-1:0] ts);
    cmd_item_t it;
    it.cmd = c;
    it.ts  = ts;
    cmd_pending.push_back(it);
    n_queued++;
  endtask

  function automatic logic [63:0] rand_span();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> $urandom_range(63, 0);
  endfunction

  // Queue one frame: a few timed segments and a commit, or some noise.
  task automatic push_frame();
    int unsigned kind;
    int unsigned nseg;
    kind = $urandom_range(99);
    if (kind < 12) begin
      enq(ftws_cmd_e'($urandom_range(3)), {$urandom, $urandom});
    end else if (kind < 14) begin
      enq(CMD_CLEAR, {$urandom, $urandom});
    end else begin
      nseg = $urandom_range(3);   // zero segments: commit with nothing timed unless one is left open
      repeat (nseg) begin
        enq(CMD_BEGIN, ts_now);
        ts_now = ts_now + rand_span();
        if ($urandom_range(9) == 0) enq(CMD_BEGIN, ts_now);  // stray begin, ignored
        enq(CMD_END, ts_now);
        ts_now = ts_now + $urandom_range(5000);
      end
      if ($urandom_range(4) == 0) begin
        // leave a segment open for the commit to close
        enq(CMD_BEGIN, ts_now);
        ts_now = ts_now + rand_span();
      end
      enq(CMD_COMMIT, ts_now);
      ts_now = ts_now + $urandom_range(100);
    end
  endtask

  // Wait until the driver has sent everything and every result has come,
  // then let the unit settle.
  task automatic drain();
    while (cmd_pending.size() > 0 || s_valid || stats_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [31:0] scale, input bit no_idle, input bit stall);
    int unsigned target;
    set_tick_scale(scale);
    calm     = no_idle;
    hold_req = hold_req | stall;
    ts_now   = {$urandom, $urandom};
    target   = n_queued + PHASE_N;
    while (n_queued < target) push_frame();
    drain();
    calm = 1'b0;
  endtask

  // ------------------------------------------------------- sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the scale register
    reg_read_check(TICK_SCALE_RST);

    // directed part at the reset scale
    enq(CMD_COMMIT, 64'd0);                    // commit with nothing timed
    enq(CMD_END,    64'd5);                    // end with no open segment
    enq(CMD_BEGIN,  64'd100);
    enq(CMD_BEGIN,  64'd200);                  // begin while open keeps start
    enq(CMD_END,    64'd100 + 64'd65536);
    enq(CMD_COMMIT, 64'd300);                  // tiny sample, fps saturates
    enq(CMD_BEGIN,  64'hFFFF_FFFF_FFFF_FFF6);
    enq(CMD_END,    64'd20);                   // counter wraps
    enq(CMD_BEGIN,  64'd0);
    enq(CMD_END,    64'hFFFF_FFFF_FFFF_FFFF);  // accumulator saturates
    enq(CMD_COMMIT, 64'hFFFF_FFFF_FFFF_FFFF);  // conversion saturates
    enq(CMD_BEGIN,  64'd5);
    enq(CMD_COMMIT, 64'd5 + (64'd1 << 40));    // commit closes open segment
    enq(CMD_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF);
    enq(CMD_COMMIT, 64'd0);                    // fresh window, zero sample
    enq(CMD_BEGIN,  64'd1000);
    enq(CMD_CLEAR,  64'hAAAA_5555_AAAA_5555);  // clear leaves segment alone
    enq(CMD_END,    64'd2000);
    enq(CMD_COMMIT, 64'h5555_AAAA_5555_AAAA);
    enq(CMD_END,    64'h0123_4567_89AB_CDEF);
    enq(CMD_BEGIN,  64'h8000_0000_0000_0000);
    enq(CMD_END,    64'h8000_0000_FFFF_FFFF);
    enq(CMD_COMMIT, 64'h8000_0001_0000_0000);
    drain();

    // random phases over several scale settings
    random_phase(32'hFFFF_FFFF, 1'b0, 1'b0);
    random_phase(32'h0000_0000, 1'b0, 1'b0);
    random_phase(32'h0001_0000, 1'b0, 1'b1);   // receiver hold-off here
    random_phase(TICK_SCALE_RST, 1'b1, 1'b0);  // no idling on either side
    random_phase($urandom, 1'b0, 1'b0);
    random_phase(32'd1, 1'b0, 1'b0);

    $display("Ran %0d commands and checked %0d frame results over %0d tick_scale writes,",
             n_in, n_frames, n_cfg);
    $display("with segment wrap, saturation, clears, stalls and full window wrap.");
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ftws_pkg.sv
design/ftws_div.sv
design/ftws_ctrl.sv
design/ftws_dp.sv
design/frame_time_window_stats_unit.sv
tb/tb_top.sv
